@@ rtl/dmrc_pkg.sv @@
// shared types and constants of the direct-mapped read cache
// geometry, address split, request and response item structs
// no dependencies
package dmrc_pkg;

	localparam int NUM_SETS   = 8;
	localparam int LINE_BYTES = 32;
	localparam int ADDR_WIDTH = 32;

	localparam int LINE_WORDS = LINE_BYTES / 8;
	localparam int OFFSET_W   = $clog2(LINE_BYTES);
	localparam int SET_W      = $clog2(NUM_SETS);
	localparam int WORD_W     = $clog2(LINE_WORDS);
	localparam int BYTE_SEL_W = 3;
	localparam int TAG_W      = ADDR_WIDTH - OFFSET_W - SET_W;
	localparam int FILL_IDX_W = 2;
	localparam int CNT_W      = 32;

	localparam logic OP_READ = 1'b0;
	localparam logic OP_FILL = 1'b1;

	typedef enum logic [1:0] {
		KIND_HIT    = 2'd0,
		KIND_FILL   = 2'd1,
		KIND_FETCH  = 2'd2,
		KIND_REJECT = 2'd3
	} kind_t;

	typedef struct packed {
		logic                  op;
		logic [31:0]           address;
		logic [FILL_IDX_W-1:0] fill_index;
		logic [63:0]           fill_data;
	} req_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data_byte;
		logic [31:0]      fetch_address;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] misses;
		logic [CNT_W-1:0] fetches;
	} rsp_t;

endpackage

@@ rtl/direct_mapped_read_cache.sv @@
// direct-mapped read-only byte cache: 8 sets of 32-byte lines
// depends on dmrc_pkg for geometry, item structs and result kinds
//
// usage:
//   req channel (req, req_valid, req_stall) carries reads and line fill words.
//   a read that hits returns its byte with kind hit. a miss returns a fetch
//   request with the line-aligned address; the line must then come in as
//   four fill items, word 0 first. the last one returns the requested byte
//   with kind fill-data. reads during a pending fill and stray or
//   out-of-order fill items come back as rejected items.
//   rsp channel (rsp, rsp_valid, rsp_stall) carries one result per item,
//   except the first three fill words of a line, which give none.
//   every result also carries the hit, miss and fetch counters after it.
// timing:
//   an item accepted into the input register is looked up there and its result
//   is written to the result register once that is free. one item per cycle
//   is sustained while rsp_stall is low; lookup and state update happen in the
//   single stage between the input register and the result register.
// reset:
//   arst_n clears all valid bits, the pending fill and the counters at once;
//   there is no clearing pass and the first item is taken right after reset.
// stall:
//   while rsp_stall holds a result, the item in the input register waits and
//   req_stall rises until the result register is free again.
module direct_mapped_read_cache
	import dmrc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic req_valid,
	output logic req_stall,
	output rsp_t rsp,
	output logic rsp_valid,
	input  logic rsp_stall
);

	// input register
	req_t item_s1;
	logic item_valid_s1;

	// cache state
	logic [NUM_SETS-1:0]   valid_q;
	logic [TAG_W-1:0]      tag_q [NUM_SETS];
	logic [63:0]           line_q [NUM_SETS*LINE_WORDS];
	logic                  pending_q;
	logic [ADDR_WIDTH-1:0] pend_addr_q;
	logic [WORD_W-1:0]     expected_q;
	logic [CNT_W-1:0]      hits_q;
	logic [CNT_W-1:0]      misses_q;
	logic [CNT_W-1:0]      fetches_q;

	// result register
	rsp_t rsp_q;
	logic rsp_valid_q;

	logic out_free;
	logic proc;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign proc      = item_valid_s1 && out_free;
	assign req_stall = item_valid_s1 && !out_free;
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	// address split
	logic [ADDR_WIDTH-1:0] addr;
	logic [SET_W-1:0]      rd_set;
	logic [WORD_W-1:0]     rd_word;
	logic [BYTE_SEL_W-1:0] rd_byte;
	logic [SET_W-1:0]      addr_set;
	logic [TAG_W-1:0]      addr_tag;
	logic [SET_W-1:0]      pend_set;
	logic [63:0]           stored_word;
	logic [63:0]           fill_word;
	logic                  hit;
	logic                  fill_ok;
	logic                  last_word;

	assign addr     = item_s1.address[ADDR_WIDTH-1:0];
	assign addr_set = addr[OFFSET_W +: SET_W];
	assign addr_tag = addr[ADDR_WIDTH-1 -: TAG_W];
	assign pend_set = pend_addr_q[OFFSET_W +: SET_W];

	// one read port into the line store: read address or pending line
	always_comb begin
		if (item_s1.op == OP_FILL) begin
			rd_set  = pend_set;
			rd_word = pend_addr_q[BYTE_SEL_W +: WORD_W];
			rd_byte = pend_addr_q[BYTE_SEL_W-1:0];
		end else begin
			rd_set  = addr_set;
			rd_word = addr[BYTE_SEL_W +: WORD_W];
			rd_byte = addr[BYTE_SEL_W-1:0];
		end
	end

	assign stored_word = line_q[{rd_set, rd_word}];
	assign hit         = valid_q[addr_set] && (tag_q[addr_set] == addr_tag);
	assign fill_ok     = pending_q && (item_s1.fill_index == FILL_IDX_W'(expected_q));
	assign last_word   = (expected_q == WORD_W'(LINE_WORDS - 1));
	// the last fill word is not in the store yet
	assign fill_word   = (rd_word == expected_q) ? item_s1.fill_data : stored_word;

	rsp_t res;
	logic res_valid;

	always_comb begin
		res               = '0;
		res.kind          = KIND_REJECT;
		res.hits          = hits_q;
		res.misses        = misses_q;
		res.fetches       = fetches_q;
		res_valid         = 1'b1;
		if (item_s1.op == OP_READ) begin
			if (pending_q) begin
				res.kind = KIND_REJECT;
			end else if (hit) begin
				res.kind      = KIND_HIT;
				res.data_byte = stored_word[8*rd_byte +: 8];
				res.hits      = hits_q + 1'b1;
			end else begin
				res.kind          = KIND_FETCH;
				res.fetch_address = 32'({addr[ADDR_WIDTH-1:OFFSET_W], {OFFSET_W{1'b0}}});
				res.misses        = misses_q + 1'b1;
				res.fetches       = fetches_q + 1'b1;
			end
		end else if (fill_ok) begin
			if (last_word) begin
				res.kind      = KIND_FILL;
				res.data_byte = fill_word[8*rd_byte +: 8];
			end else begin
				res_valid = 1'b0;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			item_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			item_s1 <= req;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			pending_q   <= 1'b0;
			pend_addr_q <= '0;
			expected_q  <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			fetches_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (proc) begin
				rsp_valid_q <= res_valid;
				hits_q      <= res.hits;
				misses_q    <= res.misses;
				fetches_q   <= res.fetches;
				if (item_s1.op == OP_READ) begin
					if (!pending_q && !hit) begin
						valid_q[addr_set] <= 1'b0;
						pending_q         <= 1'b1;
						pend_addr_q       <= addr;
						expected_q        <= '0;
					end
				end else if (fill_ok) begin
					if (last_word) begin
						valid_q[pend_set] <= 1'b1;
						pending_q         <= 1'b0;
						expected_q        <= '0;
					end else begin
						expected_q <= expected_q + 1'b1;
					end
				end
			end else if (out_free) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// tag and line storage, plus the result payload
	always_ff @(posedge clk) begin
		if (proc) begin
			rsp_q <= res;
			if (item_s1.op == OP_FILL && fill_ok) begin
				line_q[{pend_set, expected_q}] <= item_s1.fill_data;
				if (last_word) begin
					tag_q[pend_set] <= pend_addr_q[ADDR_WIDTH-1 -: TAG_W];
				end
			end
		end
	end

endmodule
